@@ rtl/virtual_fat16_sector_synth_assert.svh @@
// assertion macros shared by the rtl files
`ifndef VIRTUAL_FAT16_SECTOR_SYNTH_ASSERT_SVH
`define VIRTUAL_FAT16_SECTOR_SYNTH_ASSERT_SVH

// a implies b on every clock edge out of reset
`define VF_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// a implies b on the next clock edge out of reset
`define VF_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/vfat16_pkg.sv @@
package vfat16_pkg;

  localparam int unsigned VolSectors  = 65536;
  localparam int unsigned RootFirst   = 65;
  localparam int unsigned DataFirst   = 97;
  localparam int unsigned ClusterLast = 8180;  // last usable cluster number

  typedef enum logic [1:0] {
    MODE_PUBLISH = 2'd0,
    MODE_ADD     = 2'd1,
    MODE_READ    = 2'd2,
    MODE_TEST    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOTRDY  = 3'd1,
    ST_CHANGED = 3'd2,
    ST_BEYOND  = 3'd3,
    ST_DROPPED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    RG_NONE = 3'd0,
    RG_BOOT = 3'd1,
    RG_FAT  = 3'd2,
    RG_ROOT = 3'd3,
    RG_DATA = 3'd4
  } region_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_OUT  = 2'd2
  } fsm_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] file_size;
    logic [31:0] sector;
    logic [8:0]  byte_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  region;
    logic [7:0]  byte_value;
    logic [13:0] root_index;
    logic [2:0]  file_number;
    logic [24:0] file_offset;
    logic        from_file;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture input word
    logic exec;   // compute result and update table
  } dp_cmd_t;

  function automatic logic [7:0] boot_byte(input logic [8:0] bi);
    logic [7:0] v;
    v = 8'h00;
    case (bi)
      9'd0: v = 8'hEB;  9'd1: v = 8'h3C;  9'd2: v = 8'h90;  9'd3: v = 8'h4E;
      9'd4: v = 8'h55;  9'd5: v = 8'h43;  9'd6: v = 8'h4C;  9'd7: v = 8'h45;
      9'd8: v = 8'h4F;  9'd9: v = 8'h4F;  9'd10: v = 8'h53; 9'd12: v = 8'h02;
      9'd13: v = 8'h08; 9'd14: v = 8'h01; 9'd16: v = 8'h02; 9'd18: v = 8'h02;
      9'd21: v = 8'hF8; 9'd22: v = 8'h20; 9'd24: v = 8'h3F; 9'd26: v = 8'hFF;
      9'd34: v = 8'h01; 9'd36: v = 8'h80; 9'd38: v = 8'h29; 9'd39: v = 8'h4D;
      9'd40: v = 8'h32; 9'd41: v = 8'h56; 9'd42: v = 8'h4E; 9'd43: v = 8'h4E;
      9'd44: v = 8'h55; 9'd45: v = 8'h43; 9'd46: v = 8'h4C; 9'd47: v = 8'h45;
      9'd48: v = 8'h4F; 9'd49: v = 8'h4F; 9'd50: v = 8'h53; 9'd51: v = 8'h20;
      9'd52: v = 8'h20; 9'd53: v = 8'h20; 9'd54: v = 8'h46; 9'd55: v = 8'h41;
      9'd56: v = 8'h54; 9'd57: v = 8'h31; 9'd58: v = 8'h36; 9'd59: v = 8'h20;
      9'd60: v = 8'h20; 9'd61: v = 8'h20; 9'd510: v = 8'h55; 9'd511: v = 8'hAA;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/vfat16_ctrl.sv @@
module vfat16_ctrl
  import vfat16_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= FSM_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_EXEC;
      FSM_EXEC: state_nxt = FSM_OUT;
      FSM_OUT: begin
        if (!out_stall) state_nxt = in_valid ? FSM_EXEC : FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // next word taken while the result is delivered
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      FSM_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      FSM_EXEC: cmd.exec = 1'b1;
      FSM_OUT: begin
        out_valid = 1'b1;
        in_stall  = out_stall;
        cmd.load  = in_valid && !out_stall;
      end
      default: in_stall = 1'b1;
    endcase
  end

  `include "virtual_fat16_sector_synth_assert.svh"
  `VF_ASSERT_NXT(a_exec_out, state_r == FSM_EXEC, out_valid)
  `VF_ASSERT_IMP(a_no_dual, cmd.load, !cmd.exec)
  `VF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

@@ rtl/vfat16_dp.sv @@
module vfat16_dp
  import vfat16_pkg::*;
#(
  parameter int unsigned MAX_FILE_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  input  in_word_t  in_word,
  output out_word_t out_word
);

  localparam int unsigned IW = (MAX_FILE_SLOTS > 1) ? $clog2(MAX_FILE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_FILE_SLOTS + 1);

  in_word_t  req_r;
  out_word_t res_r, res_nxt;

  logic [13:0] ext_first_r  [MAX_FILE_SLOTS];
  logic [13:0] ext_clus_r   [MAX_FILE_SLOTS];
  logic [24:0] ext_bytes_r  [MAX_FILE_SLOTS];
  logic [CW-1:0] count_r, count_nxt;
  logic [13:0] free_r, free_nxt;
  logic full_r, full_nxt, ready_r, ready_nxt, changed_r, changed_nxt;
  logic wr_en;
  logic [IW-1:0] wr_idx;

  logic [20:0] n_clus;
  logic [21:0] run_end;
  logic [15:0] lba;
  logic [12:0] fat_idx;
  logic [13:0] key;
  logic [15:0] rel;
  logic [MAX_FILE_SLOTS-1:0] hit;
  logic [MAX_FILE_SLOTS-1:0] last;
  logic        any_hit;
  logic [IW-1:0] hit_idx;
  logic [13:0] hf;
  logic [24:0] hb;
  logic [26:0] off;
  logic [15:0] fat_v;

  function automatic logic [20:0] in_cast(input logic [31:0] s);
    return {1'b0, s[31:12]} + 21'(s[11:0] != 12'd0);
  endfunction

  assign n_clus  = 21'(in_cast(req_r.file_size));
  assign run_end = 22'(free_r) + 22'(n_clus);
  assign lba     = req_r.sector[15:0];
  assign fat_idx = {lba[4:0] - 5'd1, req_r.byte_index[8:1]};
  assign rel     = lba - 16'(DataFirst);
  assign key     = (lba < 16'(RootFirst)) ? {1'b0, fat_idx} : 14'(rel[15:3]) + 14'd2;

  // range compare against every slot, first match wins
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_FILE_SLOTS; i++) begin
      hit[i]  = (CW'(i) < count_r) && (ext_clus_r[i] != 14'd0) && (key >= ext_first_r[i])
                && ({1'b0, key} < {1'b0, ext_first_r[i]} + {1'b0, ext_clus_r[i]});
      last[i] = ({1'b0, key} == {1'b0, ext_first_r[i]} + {1'b0, ext_clus_r[i]} - 15'd1);
    end
    for (int i = MAX_FILE_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        any_hit = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  assign hf  = ext_first_r[hit_idx];
  assign hb  = ext_bytes_r[hit_idx];
  assign off = {1'b0, (key - hf), 12'd0} + {15'd0, rel[2:0], req_r.byte_index};

  always_comb begin
    if (key == 14'd0)      fat_v = 16'hFFF8;
    else if (key == 14'd1) fat_v = 16'hFFFF;
    else if (!any_hit)     fat_v = 16'h0000;
    else if (last[hit_idx]) fat_v = 16'hFFFF;
    else                   fat_v = 16'(key) + 16'd1;
  end

  always_comb begin
    res_nxt     = '0;
    count_nxt   = count_r;
    free_nxt    = free_r;
    full_nxt    = full_r;
    ready_nxt   = ready_r;
    changed_nxt = changed_r;
    wr_en       = 1'b0;
    wr_idx      = IW'(count_r);
    case (mode_t'(req_r.mode))
      MODE_PUBLISH: begin
        count_nxt = '0;
        free_nxt  = 14'd2;
        full_nxt  = 1'b0;
        if (ready_r) changed_nxt = 1'b1;
        ready_nxt = 1'b1;
      end
      MODE_ADD: begin
        if (full_r || (count_r >= CW'(MAX_FILE_SLOTS))
            || (run_end > 22'(ClusterLast) + 22'd1)) begin
          full_nxt       = 1'b1;
          res_nxt.status = ST_DROPPED;
        end else begin
          wr_en     = 1'b1;
          free_nxt  = free_r + n_clus[13:0];
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_READ: begin
        if (!ready_r) res_nxt.status = ST_NOTRDY;
        else if (req_r.sector[31:16] != 16'd0) res_nxt.status = ST_BEYOND;
        else if (lba == 16'd0) begin
          res_nxt.region     = RG_BOOT;
          res_nxt.byte_value = boot_byte(req_r.byte_index);
        end else if (lba < 16'(RootFirst)) begin
          res_nxt.region     = RG_FAT;
          res_nxt.byte_value = req_r.byte_index[0] ? fat_v[15:8] : fat_v[7:0];
        end else if (lba < 16'(DataFirst)) begin
          res_nxt.region     = RG_ROOT;
          res_nxt.root_index = {lba[4:0] - 5'd1, req_r.byte_index};
        end else begin
          res_nxt.region = RG_DATA;
          if (any_hit && (off < {2'b0, hb})) begin
            res_nxt.from_file   = 1'b1;
            res_nxt.file_number = 3'(hit_idx);
            res_nxt.file_offset = off[24:0];
          end
        end
      end
      default: begin
        if (!ready_r) res_nxt.status = ST_NOTRDY;
        else if (changed_r) begin
          changed_nxt    = 1'b0;
          res_nxt.status = ST_CHANGED;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_word;
    if (cmd.exec) res_r <= res_nxt;
    if (cmd.exec && wr_en) begin
      ext_first_r[wr_idx] <= (n_clus != 21'd0) ? free_r : 14'd0;
      ext_clus_r[wr_idx]  <= n_clus[13:0];
      ext_bytes_r[wr_idx] <= req_r.file_size[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      free_r    <= 14'd2;
      full_r    <= 1'b0;
      ready_r   <= 1'b0;
      changed_r <= 1'b0;
    end else if (cmd.exec) begin
      count_r   <= count_nxt;
      free_r    <= free_nxt;
      full_r    <= full_nxt;
      ready_r   <= ready_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign out_word = res_r;

  `include "virtual_fat16_sector_synth_assert.svh"
  `VF_ASSERT_IMP(a_count_max, 1'b1, count_r <= CW'(MAX_FILE_SLOTS))
  `VF_ASSERT_IMP(a_changed_rdy, changed_r, ready_r)
  `VF_ASSERT_IMP(a_free_min, 1'b1, free_r >= 14'd2)

endmodule

@@ rtl/virtual_fat16_sector_synth.sv @@
// virtual fat16 volume: every input word gives one result word. a word is
// first captured, then the extent compare over every file slot runs and
// the file table is updated; the result sits in an output register while the
// next word is captured, so no new word is taken before the last one is out.
// files are contiguous 4 KB cluster runs from cluster 2; a file that does not
// fit drops itself and every later add until the next begin-publish.
module virtual_fat16_sector_synth
  import vfat16_pkg::*;
#(
  parameter int unsigned MAX_FILE_SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // command path between controller and datapath
  dp_cmd_t cmd;

  vfat16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  // extent table, status flags and region decode
  vfat16_dp #(.MAX_FILE_SLOTS(MAX_FILE_SLOTS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_word (in_data),
    .out_word(out_data)
  );

endmodule
